// ===== sv/cirl_pkg.sv =====
package cirl_pkg;

	// Item modes
	typedef enum logic [1:0] {
		MODE_DENY_ALL  = 2'd0,
		MODE_ALLOW_ALL = 2'd1,
		MODE_ADD_RULE  = 2'd2,
		MODE_QUERY     = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD_ALL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_D = 3'd4;

	localparam int unsigned ID_W   = 32;
	localparam int unsigned IVL_W  = 16;
	localparam int unsigned TIME_W = 32;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE
	} state_t;

	// Command broadcast to every rule cell
	typedef struct packed {
		logic              eval;
		logic              clear;
		logic              add;
		logic              touch;
		logic              any_hit;
		logic [ID_W-1:0]   frame_id;
		logic [IVL_W-1:0]  interval;
		logic [TIME_W-1:0] now;
	} cell_cmd_t;

endpackage

// ===== sv/cirl_cell.sv =====
module cirl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cirl_pkg::cell_cmd_t cmd,
	input  logic               left_valid,
	output logic               valid,
	output logic               hit,
	output logic               pass_hit
);
	import cirl_pkg::*;

	logic              valid_q;
	logic              hit_q;
	logic              pass_q;
	logic [ID_W-1:0]   id_q;
	logic [IVL_W-1:0]  interval_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] elapsed;
	logic              take_slot;
	logic              upd_ivl;
	logic              upd_time;

	// Wrapping elapsed time since last pass
	assign elapsed = cmd.now - last_q;

	// Claim the first free slot: this one empty, left neighbor used
	assign take_slot = cmd.add && !cmd.any_hit && !valid_q && left_valid;
	assign upd_ivl   = cmd.add && cmd.any_hit && hit_q;
	assign upd_time  = cmd.touch && hit_q && pass_q;

	// Hold valid and match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			pass_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				valid_q <= 1'b0;
			end else if (take_slot) begin
				valid_q <= 1'b1;
			end
			if (cmd.eval) begin
				hit_q  <= valid_q && (id_q == cmd.frame_id);
				pass_q <= (last_q == '0) || (elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval_q});
			end
		end
	end

	// Rule contents
	always_ff @(posedge clk) begin
		if (take_slot) begin
			id_q       <= cmd.frame_id;
			interval_q <= cmd.interval;
			last_q     <= '0;
		end else begin
			if (upd_ivl) begin
				interval_q <= cmd.interval;
			end
			if (upd_time) begin
				last_q <= cmd.now;
			end
		end
	end

	assign valid    = valid_q;
	assign hit      = hit_q;
	assign pass_hit = hit_q && pass_q;

endmodule

// ===== sv/can_id_rate_limit_filter.sv =====
// CAN identifier filter with per-rule rate limiting. Each input item passes an
// accept step, a match step in which every rule cell compares its identifier
// and elapsed time in parallel, and an update step, held while the output is
// not free, that merges the cell flags, updates the table and loads the result
// register; the merge of RULES hit flags ahead of the table update sets this
// last step. A new item is taken while the previous result still waits on the
// output side. Rules live in a row of RULES cells that fill from the left;
// each cell learns from its left neighbor whether it is the next free slot.
// Configuration writes take effect at once and are meant for idle periods only.
module can_id_rate_limit_filter #(
	parameter int unsigned RULES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cirl_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
	input  logic [31:0]                       cfg_wr_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// mode[1:0], frame_id[33:2], min_interval[49:34], time_now[81:50], zero pad
	input  logic [87:0]                       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// forward[0], table_full[1], zero pad
	output logic [7:0]                        m_axis_tdata
);
	import cirl_pkg::*;

	state_t            state_q, state_d;
	logic              fwd_all_q;
	logic [ID_W-1:0]   fixed_a_q, fixed_b_q, fixed_c_q, fixed_d_q;
	logic              allow_all_q;
	mode_t             mode_q;
	logic [ID_W-1:0]   id_q;
	logic [IVL_W-1:0]  ivl_q;
	logic [TIME_W-1:0] now_q;
	logic              out_valid_q;
	logic              fwd_q, full_q;
	logic              accept, out_free, apply;
	logic              any_hit, any_pass, bypass, full, fwd;
	logic [RULES-1:0]  valid_v, hit_v, pass_v;
	cell_cmd_t         cmd;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign apply    = (state_q == ST_UPDATE) && out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_all_q <= 1'b0;
			fixed_a_q <= '0;
			fixed_b_q <= '0;
			fixed_c_q <= '0;
			fixed_d_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_wr_index)
				CFG_FWD_ALL: fwd_all_q <= cfg_wr_data[0];
				CFG_FIXED_A: fixed_a_q <= cfg_wr_data;
				CFG_FIXED_B: fixed_b_q <= cfg_wr_data;
				CFG_FIXED_C: fixed_c_q <= cfg_wr_data;
				CFG_FIXED_D: fixed_d_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(s_axis_tdata[1:0]);
			id_q   <= s_axis_tdata[33:2];
			ivl_q  <= s_axis_tdata[49:34];
			now_q  <= s_axis_tdata[81:50];
		end
	end

	// Merge cell flags
	assign any_hit  = |hit_v;
	assign any_pass = |pass_v;
	assign bypass   = fwd_all_q || allow_all_q || (id_q == fixed_a_q) ||
	                  (id_q == fixed_b_q) || (id_q == fixed_c_q) || (id_q == fixed_d_q);
	assign full     = (mode_q == MODE_ADD_RULE) && !any_hit && valid_v[RULES-1];
	assign fwd      = (mode_q == MODE_QUERY) && (bypass || any_pass);

	// Broadcast command to the cells
	always_comb begin
		cmd.eval     = (state_q == ST_MATCH);
		cmd.clear    = apply && ((mode_q == MODE_DENY_ALL) || (mode_q == MODE_ALLOW_ALL));
		cmd.add      = apply && (mode_q == MODE_ADD_RULE);
		cmd.touch    = apply && (mode_q == MODE_QUERY) && !bypass;
		cmd.any_hit  = any_hit;
		cmd.frame_id = id_q;
		cmd.interval = ivl_q;
		cmd.now      = now_q;
	end

	// Row of rule cells, each fed its left neighbor's valid bit
	for (genvar i = 0; i < RULES; i++) begin : g_cell
		logic left_valid;
		if (i == 0) begin : g_first
			assign left_valid = 1'b1;
		end else begin : g_next
			assign left_valid = valid_v[i-1];
		end
		cirl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_valid (left_valid),
			.valid      (valid_v[i]),
			.hit        (hit_v[i]),
			.pass_hit   (pass_v[i])
		);
	end

	// Allow-all flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_all_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply && (mode_q == MODE_DENY_ALL)) begin
				allow_all_q <= 1'b0;
			end else if (apply && (mode_q == MODE_ALLOW_ALL)) begin
				allow_all_q <= 1'b1;
			end
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (apply) begin
			fwd_q  <= fwd;
			full_q <= full;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, full_q, fwd_q};

endmodule
